@@ rtl/core/wapr_pkg.sv @@
package wapr_pkg;

  localparam int SAMPLE_W = 24;
  localparam int USED_W   = 5;
  localparam int TIME_W   = 32;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  localparam logic [TIME_W-1:0] INTERVAL_RESET = 32'd60000000;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // Register select bit of the APB byte address (register i at 4*i).
  localparam logic REG_INTERVAL = 1'b0;

  typedef struct packed {
    logic capture;
    logic rd_en;
    logic update;
    logic tick;
    logic div_start;
    logic div_step;
    logic load_out;
  } wapr_cmd_t;

  typedef struct packed {
    logic report_due;
    logic div_last;
  } wapr_stat_t;

endpackage

@@ rtl/core/wapr_ram.sv @@
module wapr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/wapr_ctrl.sv @@
module wapr_ctrl
  import wapr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_operation,
  output logic       in_stall,
  input  logic       out_stall,
  output logic       out_valid,
  input  wapr_stat_t stat,
  output wapr_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_UPD   = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;
  logic       out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          if (in_operation == OP_TICK) begin
            cmd.tick  = 1'b1;
            state_nxt = S_CHECK;
          end else begin
            cmd.rd_en = 1'b1;
            state_nxt = S_UPD;
          end
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = S_CHECK;
      end
      S_CHECK: begin
        if (stat.report_due) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ rtl/core/wapr_dp.sv @@
module wapr_dp
  import wapr_pkg::*;
#(
  parameter int RING_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  wapr_cmd_t           cmd,
  output wapr_stat_t          stat,
  input  logic [SAMPLE_W-1:0] in_sample,
  input  logic [TIME_W-1:0]   interval,
  output logic [SAMPLE_W-1:0] avg_out,
  output logic [USED_W-1:0]   used_out
);

  localparam int PTR_W   = $clog2(RING_DEPTH);
  localparam int CNT_W   = $clog2(RING_DEPTH + 1);
  localparam int SUM_W   = SAMPLE_W + PTR_W;
  localparam int STEP_W  = $clog2(SUM_W);
  localparam int USED_EW = (CNT_W > USED_W) ? CNT_W : USED_W;

  logic [SAMPLE_W-1:0]     sample_r;
  logic [PTR_W-1:0]        pos_r, pos_nxt;
  logic                    full_r, full_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [TIME_W-1:0]       elapsed_r, elapsed_nxt;
  logic [SAMPLE_W-1:0]     old_rd;

  logic [SUM_W-1:0]        quo_r, quo_nxt;
  logic [CNT_W-1:0]        rem_r, rem_nxt;
  logic [CNT_W-1:0]        div_by_r;
  logic                    neg_r;
  logic [STEP_W-1:0]       step_r, step_nxt;
  logic [SAMPLE_W-1:0]     avg_r;
  logic [USED_W-1:0]       used_r;

  logic [CNT_W-1:0]        count;
  logic signed [SUM_W-1:0] old_ext, new_ext;
  logic [SUM_W-1:0]        mag;
  logic [CNT_W:0]          shifted, diff;
  logic                    ge;
  logic [SUM_W-1:0]        quo_neg;
  logic [USED_EW-1:0]      used_ext;

  wapr_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (cmd.update),
    .waddr(pos_r),
    .wdata(sample_r),
    .re   (cmd.rd_en),
    .raddr(pos_r),
    .rdata(old_rd)
  );

  assign count   = full_r ? CNT_W'(RING_DEPTH) : CNT_W'(pos_r);
  assign new_ext = {{(SUM_W-SAMPLE_W){sample_r[SAMPLE_W-1]}}, sample_r};
  assign old_ext = full_r ? {{(SUM_W-SAMPLE_W){old_rd[SAMPLE_W-1]}}, old_rd} : '0;
  assign mag     = sum_r[SUM_W-1] ? (~sum_r + 1'b1) : sum_r;

  // Ring update: drop the oldest sample from the sum once the ring is full.
  always_comb begin
    pos_nxt  = pos_r;
    full_nxt = full_r;
    sum_nxt  = sum_r;
    if (cmd.update) begin
      sum_nxt = sum_r - old_ext + new_ext;
      if (pos_r == PTR_W'(RING_DEPTH - 1)) begin
        pos_nxt  = '0;
        full_nxt = 1'b1;
      end else begin
        pos_nxt = pos_r + 1'b1;
      end
    end
  end

  // Saturating tick count, restarted at each report.
  always_comb begin
    elapsed_nxt = elapsed_r;
    if (cmd.div_start) begin
      elapsed_nxt = '0;
    end else if (cmd.tick && (elapsed_r != '1)) begin
      elapsed_nxt = elapsed_r + 1'b1;
    end
  end

  // Restoring divider on the sum magnitude, one quotient bit per cycle.
  assign shifted = {rem_r, quo_r[SUM_W-1]};
  assign diff    = shifted - {1'b0, div_by_r};
  assign ge      = (shifted >= {1'b0, div_by_r});

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    if (cmd.div_start) begin
      quo_nxt  = mag;
      rem_nxt  = '0;
      step_nxt = STEP_W'(SUM_W - 1);
    end else if (cmd.div_step) begin
      quo_nxt  = {quo_r[SUM_W-2:0], ge};
      rem_nxt  = ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
      step_nxt = step_r - 1'b1;
    end
  end

  assign quo_neg  = ~quo_r + 1'b1;
  assign used_ext = USED_EW'(div_by_r);

  assign stat.report_due = (elapsed_r > interval);
  assign stat.div_last   = (step_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      full_r    <= 1'b0;
      sum_r     <= '0;
      elapsed_r <= '0;
    end else begin
      pos_r     <= pos_nxt;
      full_r    <= full_nxt;
      sum_r     <= sum_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample_r <= in_sample;
    end
    if (cmd.div_start) begin
      div_by_r <= count;
      neg_r    <= sum_r[SUM_W-1];
    end
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    step_r <= step_nxt;
    if (cmd.load_out) begin
      if (div_by_r == '0) begin
        avg_r <= '0;
      end else if (neg_r) begin
        avg_r <= quo_neg[SAMPLE_W-1:0];
      end else begin
        avg_r <= quo_r[SAMPLE_W-1:0];
      end
      used_r <= used_ext[USED_W-1:0];
    end
  end

  assign avg_out  = avg_r;
  assign used_out = used_r;

endmodule

@@ rtl/core/windowed_average_periodic_report_unit.sv @@
// Windowed average with periodic report. Each request is either a sensor
// sample (signed, hundredths of a unit) or one time tick. Samples go into a
// ring of the last RING_DEPTH entries with a running sum; ticks advance a
// saturating elapsed counter. After every request the counter is compared
// against report_interval (APB register at byte 0, reset 60000000); once it
// is strictly greater, the block reports the average of the stored samples,
// truncated toward zero, together with the number of samples used (0 and 0
// when no sample has arrived yet, the count truncated to five bits), and
// restarts the counter. A tick request goes straight to the interval check; a
// sample request does a ring read, then the write and sum update, then the
// interval check. A request that triggers a report then runs the bit-serial
// divider over SUM_W = 24 + log2(RING_DEPTH) bits, 28 at the default depth.
// One request is in flight at a time; the result register lets the next
// request enter while a report waits to be taken, and a new report holds
// only if the previous one is still stalled.
module windowed_average_periodic_report_unit
  import wapr_pkg::*;
#(
  parameter int RING_DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,

  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_operation,
  input  logic signed [SAMPLE_W-1:0] in_sample_value,

  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] out_average_value,
  output logic [USED_W-1:0]          out_samples_used,

  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ADDR_W-1:0]          paddr,
  input  logic [DATA_W-1:0]          pwdata,
  output logic [DATA_W-1:0]          prdata,
  output logic                       pready
);

  wapr_cmd_t         cmd;
  wapr_stat_t        stat;
  logic [TIME_W-1:0] interval_r, interval_nxt;
  logic              cfg_wr;

  // Configuration: single interval register, written in the APB access phase.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_INTERVAL) ? interval_r : '0;

  always_comb begin
    interval_nxt = interval_r;
    if (cfg_wr && (paddr[2] == REG_INTERVAL)) begin
      interval_nxt = pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= INTERVAL_RESET;
    end else begin
      interval_r <= interval_nxt;
    end
  end

  // Sequencer: read and update for samples, then check, and divide when due.
  wapr_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_operation(in_operation),
    .in_stall    (in_stall),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .stat        (stat),
    .cmd         (cmd)
  );

  // Ring, running sum, tick counter, divider and result register.
  wapr_dp #(
    .RING_DEPTH(RING_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .in_sample(in_sample_value),
    .interval (interval_r),
    .avg_out  (out_average_value),
    .used_out (out_samples_used)
  );

`ifndef NO_ASSERTIONS
  // An accepted request always keeps the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted back to back");

  // A report is only raised while a request is being processed.
  a_report_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("report raised while idle");

  // An empty ring reports a zero average.
  a_empty_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_samples_used == '0) && (RING_DEPTH < 32))
      |-> (out_average_value == '0))
    else $error("nonzero average over no samples");
`endif

endmodule
